FILE: hw/rtl/vn_pkg.sv
package vn_pkg;

  localparam int CW         = 16;
  localparam int FIELD_W    = 16;
  localparam int LANES      = 3;
  localparam int MAG_W      = 24;
  localparam int SUM_W      = 2 * CW;
  localparam int RAD_W      = SUM_W + 16;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_STEPS + 2;
  localparam int Q_W        = 15;
  localparam int NUM_SHIFT  = 22;
  localparam int DIV_REM_W  = CW + NUM_SHIFT + 1;
  localparam int UNIT_W     = 16;

  localparam int PRE_STAGES = 3;
  localparam int SQ_FIRST   = PRE_STAGES;
  localparam int DIV_FIRST  = SQ_FIRST + ROOT_STEPS;
  localparam int OUT_STAGE  = DIV_FIRST + Q_W;
  localparam int NS         = OUT_STAGE + 1;

  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int OUT_DATA_W = MAG_W + 3 * UNIT_W;

  typedef logic [CW-1:0]        comp_abs_t;
  typedef logic [SQ_REM_W-1:0]  sq_rem_t;
  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [DIV_REM_W-1:0] div_rem_t;
  typedef logic [Q_W-1:0]       quot_t;

endpackage

FILE: hw/rtl/vector3_normalize.sv
// channel | dir | tdata fields (low bit up)                         | tuser
// s_*     | in  | x_in[15:0], y_in[31:16], z_in[47:32]              | -
// m_*     | out | magnitude[23:0], unit_x[39:24], unit_y[55:40],     | zero_vector
//         |     | unit_z[71:56]                                      |
// Stages: abs, square and sum, 24 root steps (one bit each),
// 15 divide steps (one quotient bit each, three lanes), one output register.
// One vector per cycle unless m_tready stalls; each stage holds while the next is full,
// so bubbles collapse and a stalled output still lets upstream stages fill.
// rst clears all valid bits; data registers are not reset.
module vector3_normalize (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [vn_pkg::IN_DATA_W-1:0]    s_tdata,   // x_in, y_in, z_in
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [vn_pkg::OUT_DATA_W-1:0]   m_tdata,   // magnitude, unit_x, unit_y, unit_z
  output logic                            m_tuser    // zero_vector
);

  logic [vn_pkg::NS-1:0] vld;
  logic [vn_pkg::NS:0]   rdy;

  vn_pkg::comp_abs_t        in_abs [vn_pkg::LANES];
  logic [vn_pkg::LANES-1:0] in_neg;
  logic                     in_zero;

  vn_pkg::comp_abs_t cabs [vn_pkg::DIV_FIRST][vn_pkg::LANES];
  logic [vn_pkg::LANES-1:0] cneg [vn_pkg::NS];
  logic czero [vn_pkg::NS];

  logic [vn_pkg::SUM_W-1:0] sq [vn_pkg::LANES];
  logic [vn_pkg::SUM_W-1:0] ssum [vn_pkg::PRE_STAGES-1:vn_pkg::DIV_FIRST-2];
  vn_pkg::sq_rem_t srem [vn_pkg::ROOT_STEPS];
  vn_pkg::mag_t    sroot [vn_pkg::ROOT_STEPS];

  vn_pkg::mag_t     dmag [vn_pkg::Q_W];
  vn_pkg::div_rem_t drem [vn_pkg::Q_W][vn_pkg::LANES];
  vn_pkg::quot_t    dq   [vn_pkg::Q_W][vn_pkg::LANES];

  vn_pkg::mag_t omag;
  logic [vn_pkg::UNIT_W-1:0] ounit [vn_pkg::LANES];
  logic ozero;

  always_comb begin
    rdy[vn_pkg::NS] = m_tready;
    for (int i = vn_pkg::NS - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < vn_pkg::NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: sign extend and absolute value
  always_comb begin
    logic signed [vn_pkg::CW:0] c;
    logic [vn_pkg::CW:0]        a;
    in_zero = 1'b1;
    for (int l = 0; l < vn_pkg::LANES; l++) begin
      c = {s_tdata[l*vn_pkg::FIELD_W + vn_pkg::CW - 1],
           s_tdata[l*vn_pkg::FIELD_W +: vn_pkg::CW]};
      a = c[vn_pkg::CW] ? -c : c;
      in_abs[l] = a[vn_pkg::CW-1:0];
      in_neg[l] = c[vn_pkg::CW];
      if (c != '0) in_zero = 1'b0;
    end
  end

  // carry of sign, magnitude and zero flag
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cabs[0]  <= in_abs;
      cneg[0]  <= in_neg;
      czero[0] <= in_zero;
    end
    for (int i = 1; i < vn_pkg::NS; i++) begin
      if (rdy[i]) begin
        cneg[i]  <= cneg[i-1];
        czero[i] <= czero[i-1];
      end
    end
    for (int i = 1; i < vn_pkg::DIV_FIRST; i++) begin
      if (rdy[i]) cabs[i] <= cabs[i-1];
    end
  end

  // stage 1: squares, stage 2: sum
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < vn_pkg::LANES; l++) begin
        sq[l] <= cabs[0][l] * cabs[0][l];
      end
    end
    if (rdy[2]) ssum[2] <= sq[0] + sq[1] + sq[2];
    for (int i = vn_pkg::SQ_FIRST; i < vn_pkg::DIV_FIRST - 1; i++) begin
      if (rdy[i]) ssum[i] <= ssum[i-1];
    end
  end

  // root of sum * 65536, one result bit per stage
  always_ff @(posedge clk) begin
    logic [vn_pkg::RAD_W-1:0]    x;
    logic [vn_pkg::SQ_REM_W+1:0] rsh;
    logic [vn_pkg::SQ_REM_W+1:0] trial;
    vn_pkg::sq_rem_t             rprev;
    vn_pkg::mag_t                qprev;
    for (int k = 0; k < vn_pkg::ROOT_STEPS; k++) begin
      if (rdy[vn_pkg::SQ_FIRST + k]) begin
        x     = {ssum[vn_pkg::SQ_FIRST + k - 1], 16'd0};
        rprev = (k == 0) ? '0 : srem[(k == 0) ? 0 : k - 1];
        qprev = (k == 0) ? '0 : sroot[(k == 0) ? 0 : k - 1];
        rsh   = {rprev, x[2*(vn_pkg::ROOT_STEPS-1-k) +: 2]};
        trial = {2'b00, qprev, 2'b01};
        if (rsh >= trial) begin
          srem[k]  <= vn_pkg::SQ_REM_W'(rsh - trial);
          sroot[k] <= {qprev[vn_pkg::MAG_W-2:0], 1'b1};
        end else begin
          srem[k]  <= vn_pkg::SQ_REM_W'(rsh);
          sroot[k] <= {qprev[vn_pkg::MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // restoring divide, one quotient bit per stage, three lanes
  always_ff @(posedge clk) begin
    vn_pkg::div_rem_t rprev;
    vn_pkg::div_rem_t dv;
    vn_pkg::quot_t    qprev;
    vn_pkg::mag_t     m;
    for (int j = 0; j < vn_pkg::Q_W; j++) begin
      if (rdy[vn_pkg::DIV_FIRST + j]) begin
        m = (j == 0) ? sroot[vn_pkg::ROOT_STEPS-1] : dmag[(j == 0) ? 0 : j - 1];
        dmag[j] <= m;
        dv = vn_pkg::DIV_REM_W'(m) << (vn_pkg::Q_W - 1 - j);
        for (int l = 0; l < vn_pkg::LANES; l++) begin
          rprev = (j == 0)
                ? (vn_pkg::DIV_REM_W'(cabs[vn_pkg::DIV_FIRST-1][l]) << vn_pkg::NUM_SHIFT)
                : drem[(j == 0) ? 0 : j - 1][l];
          qprev = (j == 0) ? '0 : dq[(j == 0) ? 0 : j - 1][l];
          if (rprev >= dv) begin
            drem[j][l] <= rprev - dv;
            dq[j][l]   <= {qprev[vn_pkg::Q_W-2:0], 1'b1};
          end else begin
            drem[j][l] <= rprev;
            dq[j][l]   <= {qprev[vn_pkg::Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output register: sign restore and zero vector
  always_ff @(posedge clk) begin
    logic [vn_pkg::UNIT_W-1:0] u;
    if (rdy[vn_pkg::OUT_STAGE]) begin
      omag  <= czero[vn_pkg::OUT_STAGE-1] ? '0 : dmag[vn_pkg::Q_W-1];
      ozero <= czero[vn_pkg::OUT_STAGE-1];
      for (int l = 0; l < vn_pkg::LANES; l++) begin
        u = vn_pkg::UNIT_W'(dq[vn_pkg::Q_W-1][l]);
        if (czero[vn_pkg::OUT_STAGE-1]) ounit[l] <= '0;
        else ounit[l] <= cneg[vn_pkg::OUT_STAGE-1][l] ? -u : u;
      end
    end
  end

  assign m_tvalid = vld[vn_pkg::OUT_STAGE];
  assign m_tdata  = {ounit[2], ounit[1], ounit[0], omag};
  assign m_tuser  = ozero;

endmodule

FILE: hw/rtl/vn_checker.sv
module vn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [vn_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                          m_tuser
);

  logic signed [vn_pkg::UNIT_W-1:0] ux, uy, uz;
  assign ux = m_tdata[vn_pkg::MAG_W +: vn_pkg::UNIT_W];
  assign uy = m_tdata[vn_pkg::MAG_W + vn_pkg::UNIT_W +: vn_pkg::UNIT_W];
  assign uz = m_tdata[vn_pkg::MAG_W + 2*vn_pkg::UNIT_W +: vn_pkg::UNIT_W];

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero vector with nonzero fields");

  a_mag_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[vn_pkg::MAG_W-1:0] != '0)
    else $error("nonzero vector with zero magnitude");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ux <= 16384 && ux >= -16384 && uy <= 16384 && uy >= -16384
                 && uz <= 16384 && uz >= -16384)
    else $error("unit component out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec_t;

  typedef struct {
    logic [23:0] mag;
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic        zero;
  } norm_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [vn_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [vn_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;

  vector3_normalize dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  vec_t  vec_q[$];
  norm_t norm_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    stim_done = 0;
  bit    no_idle = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned lo = 0, hi = 64'd4294967296, mid;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [15:0] unit_comp(longint c, longint unsigned mag);
    longint unsigned a, q;
    a = (c < 0) ? -c : c;
    q = (a << 22) / mag;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic norm_t normalize(vec_t v);
    norm_t r;
    longint cx, cy, cz;
    longint unsigned s, mag;
    cx = v.x;
    cy = v.y;
    cz = v.z;
    s = cx * cx + cy * cy + cz * cz;
    if (s == 0) begin
      r = '{0, 0, 0, 0, 1'b1};
      return r;
    end
    mag = isqrt(s << 16);
    r.mag = (mag > 64'hFFFFFF) ? 24'hFFFFFF : mag[23:0];
    r.ux = unit_comp(cx, mag);
    r.uy = unit_comp(cy, mag);
    r.uz = unit_comp(cz, mag);
    r.zero = 1'b0;
    return r;
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    case ($urandom_range(0, 3))
      0: v = {16'($urandom_range(0, 16) - 8), 16'($urandom_range(0, 16) - 8),
              16'($urandom_range(0, 16) - 8)};
      1: v = {16'($urandom), 16'h0, 16'h0} >> (16 * $urandom_range(0, 2));
      default: v = {16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (vec_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
        vec_t v;
        v = vec_q.pop_front();
        s_tvalid <= 1;
        s_tdata <= v;
        norm_q.push_back(normalize(v));
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      m_tready <= no_idle || $urandom_range(0, 99) >= 26;
      if (m_tvalid && m_tready) begin
        if (norm_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected transaction %h", m_tdata);
        end else begin
          norm_t e;
          e = norm_q.pop_front();
          if (m_tdata !== {e.uz, e.uy, e.ux, e.mag} || m_tuser !== e.zero) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch exp mag=%h u=%h,%h,%h z=%b got %h z=%b",
                       e.mag, e.ux, e.uy, e.uz, e.zero, m_tdata, m_tuser);
          end
        end
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("FAIL vector3_normalize");
      $finish;
    end
  end

  initial begin
    int k;
    vec_t d[$];
    d = '{'{0, 0, 0}, '{16'sh7fff, 0, 0}, '{-16'sh8000, 0, 0},
          '{0, 16'sh7fff, 0}, '{0, -16'sh8000, 0}, '{0, 0, 16'sh7fff},
          '{0, 0, -16'sh8000}, '{16'sh7fff, 16'sh7fff, 16'sh7fff},
          '{-16'sh8000, -16'sh8000, -16'sh8000}, '{1, 0, 0}, '{-1, 0, 0},
          '{0, 0, 1}, '{1, 1, 1}, '{-1, -1, -1}, '{256, 0, 0},
          '{16'sh7fff, -16'sh8000, 1}, '{16'hffff, 16'hffff, 16'hffff},
          '{16'h5555, 16'haaaa, 16'h5555}, '{16'haaaa, 16'h5555, 16'haaaa}};
    repeat (9) @(posedge clk);
    rst <= 0;
    foreach (d[i]) vec_q.push_back(d[i]);
    for (k = 0; k < 1750; k++) vec_q.push_back(rand_vec());
    while (vec_q.size() > 1100) @(posedge clk);
    no_idle <= 1;
    while (vec_q.size() > 700) @(posedge clk);
    no_idle <= 0;
    while (vec_q.size() > 0 || (s_tvalid && !s_tready)) @(posedge clk);
    while (norm_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("PASS vector3_normalize");
    else $display("FAIL vector3_normalize");
    $finish;
  end
endmodule
